// File: design/assert_macros.svh
// Assertion macros shared by the page cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define LPC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("page cache assertion failed");
// Antecedent implies consequent on the following edge.
`define LPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("page cache assertion failed");
`else
`define LPC_ASSERT(lbl, clk, rst_n, prop)
`define LPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/lpc_pkg.sv
// Types and codes shared by the page cache controller and datapath.
package lpc_pkg;

	typedef enum logic [1:0] {
		CMD_FETCH = 2'd0,
		CMD_UNPIN = 2'd1,
		CMD_DIRTY = 2'd2,
		CMD_FLUSH = 2'd3
	} cmd_t;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOSLOT  = 2'd1;
	localparam logic [1:0] STAT_IGNORED = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [23:0] page_id;
		logic [7:0]  slot_index;
	} in_t;

	typedef struct packed {
		logic [7:0]  slot;
		logic        hit;
		logic        needs_fill;
		logic        writeback_valid;
		logic [23:0] writeback_page;
		logic [1:0]  status;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [23:0] page;
		logic [15:0] pin;
		logic        dirty;
	} entry_t;

	typedef enum logic [2:0] {
		EM_NONE, EM_FETCH, EM_STATUS, EM_FLITEM, EM_CLOSE
	} emit_t;

	typedef enum logic [1:0] {AD_CNT, AD_SEL, AD_SIDX} addr_t;

	typedef enum logic [2:0] {WD_HIT, WD_NEW, WD_UNPIN, WD_DIRTY, WD_CLEAN} wd_t;

	typedef enum logic [1:0] {SS_CNT, SS_USED, SS_OLDEST, SS_NEWER} selsrc_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SR_RD, S_SR_CHK, S_H_WR, S_FREE, S_NEW_WR, S_VW_INIT, S_VW_RD,
		S_VW_CHK, S_V_WR, S_MN1, S_MN2, S_MD_RD, S_MD_WR, S_FL_RD, S_FL_CHK
	} state_t;

	typedef struct packed {
		logic       ld_in;
		logic       cnt_clr;
		logic       cnt_inc;
		addr_t      addr;
		logic       rd;
		logic       wr;
		wd_t        wd;
		logic       sel_ld;
		selsrc_t    sel_src;
		logic       used_inc;
		logic       hit_set;
		logic       wb_cap;
		logic       unlink;
		logic       mn1;
		logic       mn2;
		emit_t      emit;
		logic [1:0] stat;
	} ctl_t;

	typedef struct packed {
		logic cnt_lt_used;
		logic used_full;
		logic match;
		logic pin_nz;
		logic dirty;
		logic page_nz;
		logic sel_none;
		logic sidx_ok;
	} dps_t;

endpackage

// File: design/lpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/lpc_ctrl.sv
// Command sequencer for the page cache: walks search, victim, relink, mark-dirty and flush steps.
`include "assert_macros.svh"
module lpc_ctrl
	import lpc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] command,
	input  dps_t       st,
	output ctl_t       c,
	output logic       busy
);

	state_t state_q, state_d;
	cmd_t   cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (c.ld_in) begin
			cmd_q <= cmd_t'(command);
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		c       = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					c.ld_in   = 1'b1;
					c.cnt_clr = 1'b1;
					case (cmd_t'(command))
						CMD_FETCH: state_d = S_SR_RD;
						CMD_UNPIN: state_d = S_SR_RD;
						CMD_DIRTY: state_d = S_MD_RD;
						default:   state_d = S_FL_RD;
					endcase
				end
			end
			S_SR_RD: begin
				if (st.cnt_lt_used) begin
					c.addr  = AD_CNT;
					c.rd    = 1'b1;
					state_d = S_SR_CHK;
				end else if (cmd_q == CMD_FETCH) begin
					state_d = st.used_full ? S_VW_INIT : S_FREE;
				end else begin
					c.emit  = EM_STATUS;
					c.stat  = STAT_IGNORED;
					state_d = S_IDLE;
				end
			end
			S_SR_CHK: begin
				if (!st.match) begin
					c.cnt_inc = 1'b1;
					state_d   = S_SR_RD;
				end else if (cmd_q == CMD_FETCH) begin
					c.sel_ld  = 1'b1;
					c.sel_src = SS_CNT;
					c.hit_set = 1'b1;
					state_d   = S_H_WR;
				end else begin
					c.emit  = EM_STATUS;
					c.stat  = st.pin_nz ? STAT_OK : STAT_IGNORED;
					c.addr  = AD_CNT;
					c.wr    = st.pin_nz;
					c.wd    = WD_UNPIN;
					state_d = S_IDLE;
				end
			end
			S_H_WR: begin
				c.addr   = AD_SEL;
				c.wr     = 1'b1;
				c.wd     = WD_HIT;
				c.unlink = 1'b1;
				state_d  = S_MN1;
			end
			S_FREE: begin
				c.sel_ld   = 1'b1;
				c.sel_src  = SS_USED;
				c.used_inc = 1'b1;
				state_d    = S_NEW_WR;
			end
			S_NEW_WR: begin
				c.addr  = AD_SEL;
				c.wr    = 1'b1;
				c.wd    = WD_NEW;
				state_d = S_MN1;
			end
			S_VW_INIT: begin
				c.sel_ld  = 1'b1;
				c.sel_src = SS_OLDEST;
				state_d   = S_VW_RD;
			end
			S_VW_RD: begin
				if (st.sel_none) begin
					c.emit  = EM_STATUS;
					c.stat  = STAT_NOSLOT;
					state_d = S_IDLE;
				end else begin
					c.addr  = AD_SEL;
					c.rd    = 1'b1;
					state_d = S_VW_CHK;
				end
			end
			S_VW_CHK: begin
				if (st.pin_nz) begin
					c.sel_ld  = 1'b1;
					c.sel_src = SS_NEWER;
					state_d   = S_VW_RD;
				end else begin
					c.wb_cap = 1'b1;
					state_d  = S_V_WR;
				end
			end
			S_V_WR: begin
				c.addr   = AD_SEL;
				c.wr     = 1'b1;
				c.wd     = WD_NEW;
				c.unlink = 1'b1;
				state_d  = S_MN1;
			end
			S_MN1: begin
				c.mn1   = 1'b1;
				state_d = S_MN2;
			end
			S_MN2: begin
				c.mn2   = 1'b1;
				c.emit  = EM_FETCH;
				state_d = S_IDLE;
			end
			S_MD_RD: begin
				if (st.sidx_ok) begin
					c.addr  = AD_SIDX;
					c.rd    = 1'b1;
					state_d = S_MD_WR;
				end else begin
					c.emit  = EM_STATUS;
					c.stat  = STAT_OK;
					state_d = S_IDLE;
				end
			end
			S_MD_WR: begin
				c.addr  = AD_SIDX;
				c.wr    = 1'b1;
				c.wd    = WD_DIRTY;
				c.emit  = EM_STATUS;
				c.stat  = STAT_OK;
				state_d = S_IDLE;
			end
			S_FL_RD: begin
				if (st.cnt_lt_used) begin
					c.addr  = AD_CNT;
					c.rd    = 1'b1;
					state_d = S_FL_CHK;
				end else begin
					c.emit  = EM_CLOSE;
					state_d = S_IDLE;
				end
			end
			S_FL_CHK: begin
				c.addr    = AD_CNT;
				c.wr      = 1'b1;
				c.wd      = WD_CLEAN;
				c.cnt_inc = 1'b1;
				if (st.dirty && st.page_nz) begin
					c.emit = EM_FLITEM;
				end
				state_d = S_FL_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// A relink always follows an entry write that unlinked or installed.
	`LPC_ASSERT_NEXT(a_mn1_after_wr, clk, arst_n, c.unlink, state_q == S_MN1)

endmodule

// File: design/lpc_dp.sv
// Page cache datapath: slot tables, LRU links, counters and result register.
`include "assert_macros.svh"
module lpc_dp
	import lpc_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  in_t  item,
	input  ctl_t c,
	output dps_t st,
	output out_t result,
	output logic done
);

	localparam int SW = $clog2(NUM_SLOTS);
	localparam int LW = $clog2(NUM_SLOTS + 1);
	localparam logic [LW-1:0] NONE = LW'(NUM_SLOTS);

	logic [23:0]   page_id_q;
	logic [7:0]    slot_index_q;
	logic [LW-1:0] cnt_q, sel_q, used_q, newest_q, oldest_q;
	logic          hit_q, wb_q;
	logic [23:0]   wbp_q;
	out_t          res_q;
	logic          done_q;

	entry_t        ent_rd, ent_wd;
	logic [LW-1:0] older_rd, newer_rd;
	logic [SW-1:0] ad;

	logic          ow_en, nw_en;
	logic [SW-1:0] ow_ad, nw_ad;
	logic [LW-1:0] ow_d, nw_d;

	always_comb begin
		case (c.addr)
			AD_CNT:  ad = cnt_q[SW-1:0];
			AD_SEL:  ad = sel_q[SW-1:0];
			AD_SIDX: ad = SW'(slot_index_q);
			default: ad = cnt_q[SW-1:0];
		endcase
	end

	always_comb begin
		ent_wd = ent_rd;
		case (c.wd)
			WD_HIT:   ent_wd.pin = (&ent_rd.pin) ? ent_rd.pin : ent_rd.pin + 16'd1;
			WD_NEW:   ent_wd = '{page: page_id_q, pin: 16'd1, dirty: 1'b0};
			WD_UNPIN: ent_wd.pin = ent_rd.pin - 16'd1;
			WD_DIRTY: ent_wd.dirty = 1'b1;
			WD_CLEAN: ent_wd.dirty = 1'b0;
			default:  ent_wd = ent_rd;
		endcase
	end

	// link writes: unlink patches both neighbors, mn1/mn2 put the slot on top
	always_comb begin
		ow_en = 1'b0;
		ow_ad = sel_q[SW-1:0];
		ow_d  = newest_q;
		nw_en = 1'b0;
		nw_ad = sel_q[SW-1:0];
		nw_d  = NONE;
		if (c.unlink) begin
			ow_en = (newer_rd != NONE);
			ow_ad = newer_rd[SW-1:0];
			ow_d  = older_rd;
			nw_en = (older_rd != NONE);
			nw_ad = older_rd[SW-1:0];
			nw_d  = newer_rd;
		end else if (c.mn1) begin
			ow_en = 1'b1;
			nw_en = 1'b1;
		end else if (c.mn2) begin
			nw_en = (newest_q != NONE);
			nw_ad = newest_q[SW-1:0];
			nw_d  = sel_q;
		end
	end

	lpc_ram #(.WIDTH($bits(entry_t)), .DEPTH(NUM_SLOTS)) u_ent (
		.clk(clk), .we(c.wr), .waddr(ad), .wdata(ent_wd),
		.re(c.rd), .raddr(ad), .rdata(ent_rd)
	);

	lpc_ram #(.WIDTH(LW), .DEPTH(NUM_SLOTS)) u_older (
		.clk(clk), .we(ow_en), .waddr(ow_ad), .wdata(ow_d),
		.re(c.rd), .raddr(ad), .rdata(older_rd)
	);

	lpc_ram #(.WIDTH(LW), .DEPTH(NUM_SLOTS)) u_newer (
		.clk(clk), .we(nw_en), .waddr(nw_ad), .wdata(nw_d),
		.re(c.rd), .raddr(ad), .rdata(newer_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			newest_q <= NONE;
			oldest_q <= NONE;
			done_q   <= 1'b0;
		end else begin
			done_q <= (c.emit != EM_NONE);
			if (c.used_inc) begin
				used_q <= used_q + 1'b1;
			end
			if (c.unlink) begin
				if (newer_rd == NONE) begin
					newest_q <= older_rd;
				end
				if (older_rd == NONE) begin
					oldest_q <= newer_rd;
				end
			end
			if (c.mn2) begin
				newest_q <= sel_q;
				if (oldest_q == NONE) begin
					oldest_q <= sel_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (c.ld_in) begin
			page_id_q    <= item.page_id;
			slot_index_q <= item.slot_index;
			hit_q        <= 1'b0;
			wb_q         <= 1'b0;
			wbp_q        <= '0;
		end
		if (c.cnt_clr) begin
			cnt_q <= '0;
		end else if (c.cnt_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (c.sel_ld) begin
			case (c.sel_src)
				SS_CNT:    sel_q <= cnt_q;
				SS_USED:   sel_q <= used_q;
				SS_OLDEST: sel_q <= oldest_q;
				SS_NEWER:  sel_q <= newer_rd;
				default:   sel_q <= cnt_q;
			endcase
		end
		if (c.hit_set) begin
			hit_q <= 1'b1;
		end
		if (c.wb_cap) begin
			wb_q  <= ent_rd.dirty;
			wbp_q <= ent_rd.dirty ? ent_rd.page : 24'd0;
		end
		case (c.emit)
			EM_FETCH: begin
				res_q <= '{slot: 8'(sel_q), hit: hit_q, needs_fill: !hit_q,
					writeback_valid: wb_q, writeback_page: wbp_q,
					status: STAT_OK, last: 1'b1};
			end
			EM_STATUS: begin
				res_q <= '{slot: 8'd0, hit: 1'b0, needs_fill: 1'b0,
					writeback_valid: 1'b0, writeback_page: 24'd0,
					status: c.stat, last: 1'b1};
			end
			EM_FLITEM: begin
				res_q <= '{slot: 8'(cnt_q), hit: 1'b0, needs_fill: 1'b0,
					writeback_valid: 1'b1, writeback_page: ent_rd.page,
					status: STAT_OK, last: 1'b0};
			end
			EM_CLOSE: begin
				res_q <= '{slot: 8'd0, hit: 1'b0, needs_fill: 1'b0,
					writeback_valid: 1'b0, writeback_page: 24'd0,
					status: STAT_OK, last: 1'b1};
			end
			default: begin
			end
		endcase
	end

	assign st.cnt_lt_used = (cnt_q < used_q);
	assign st.used_full   = (used_q == NONE);
	assign st.match       = (ent_rd.page == page_id_q);
	assign st.pin_nz      = |ent_rd.pin;
	assign st.dirty       = ent_rd.dirty;
	assign st.page_nz     = |ent_rd.page;
	assign st.sel_none    = (sel_q == NONE);
	assign st.sidx_ok     = ({1'b0, slot_index_q} < 9'(used_q));

	assign result = res_q;
	assign done   = done_q;

	`LPC_ASSERT(a_used_bound, clk, arst_n, used_q <= NONE)
	`LPC_ASSERT(a_ends_paired, clk, arst_n, (newest_q == NONE) == (oldest_q == NONE))
	`LPC_ASSERT(a_empty_list, clk, arst_n, (used_q != '0) || (newest_q == NONE))

endmodule

// File: design/lru_pinned_page_cache_core.sv
// Top level of the pinned LRU page cache slot manager.
//
// Usage:
//   An item beat (command, page_id, slot_index) is taken at a clock edge with
//   start high and busy low. Commands: fetch and pin, unpin, mark slot dirty,
//   flush dirty slots. Each result beat is on result for one cycle with done
//   high; the receiver must take it then, there is no back-pressure.
//   Fetch, unpin and mark dirty give one beat with last set. Flush gives one
//   beat per dirty in-use slot holding a nonzero page, in slot order, then a
//   closing beat with last set.
// Slot walks: each slot visited takes a RAM read state, then a compare state,
//   since the slot tables sit in registered-read RAMs and the victim walk
//   follows links.
//   One command is worked at a time; busy stays high until its last beat is
//   launched, and the next command may start while that beat is shown.
// Reset: arst_n clears the occupancy count and the LRU ends; slot tables
//   need no clearing since only slots below the occupancy count are read.
module lru_pinned_page_cache_core
	import lpc_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  in_t  item,
	output logic busy,
	output logic done,
	output out_t result
);

	ctl_t ctl;
	dps_t dps;

	// sequencer: owns the state, issues one datapath command per cycle
	lpc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .command(item.command),
		.st(dps), .c(ctl), .busy(busy)
	);

	// datapath: slot RAMs, LRU link RAMs, counters and the result register
	lpc_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .c(ctl),
		.st(dps), .result(result), .done(done)
	);

endmodule
